FILE: design/oaids_pkg.sv
// Package for the ordered list store: sizes, operation and status codes,
// the per-cell control bundle and the value narrowing helper.
// No dependencies.
`default_nettype none

package oaids_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 7;
  localparam int WIDE_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_REM_BACK  = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;
  localparam logic [2:0] OP_SEARCH    = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  // Status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef logic [VALUE_WIDTH-1:0] entry_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             srch;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    entry_t           val;
  } cell_ctrl_t;

  // Sign-extend the 32-bit request value, then keep the stored width.
  function automatic entry_t to_entry(input logic [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return w[VALUE_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/ordered_array_insert_delete_search_top.sv
// Top level of the ordered list store: request decode, count, the row of
// cells, the match encoder and the result register.
// Depends on oaids_pkg, oaids_cell, oaids_prio.
//
//   channel  | direction | tdata fields (low bit first)
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | operation[2:0] position[9:3] value[41:10], pad 0
//   m_axis   | out       | status[2:0] found_index[8:3] entry_count[15:9]
//
// A successful insert or remove shifts or loads the cells from the target up
// at the transfer edge, and the result register loads at the same edge; clear
// changes only the count. On a search the cells register their compares, then
// the encoder picks the lowest match. One request is in work at a time; a new
// one is taken while no search is pending and the result register is empty or
// being read. Reset clears count, state and valid; entries need no clearing.
`default_nettype none

module ordered_array_insert_delete_search_top
  import oaids_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // operation, position, value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // status, found_index, entry_count
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SRCH = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [2:0]       status;
  logic [2:0]       res_status;
  logic [5:0]       found_index;
  logic [6:0]       entry_count;

  logic [2:0]       in_op;
  logic [POS_W-1:0] in_pos;
  logic [31:0]      in_value;
  logic             accept;
  logic [WIDE_W-1:0] count_w;
  logic [WIDE_W-1:0] pos_w;
  logic [WIDE_W-1:0] ins_pos;

  cell_ctrl_t          ctrl;
  entry_t              cell_data [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic                hit_any;
  logic [IDX_W-1:0]    hit_idx;

  assign in_op    = s_tdata[2:0];
  assign in_pos   = s_tdata[9:3];
  assign in_value = s_tdata[41:10];

  // hold off transfers while in reset
  assign s_tready = !rst && (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {entry_count, found_index, status};

  assign count_w = WIDE_W'(count);
  assign pos_w   = WIDE_W'(in_pos);

  always_comb begin
    ctrl       = '0;
    ctrl.val   = to_entry(in_value);
    ctrl.cnt   = count;
    res_status = ST_DONE;
    count_next = count;
    ins_pos    = (in_op == OP_INS_FRONT) ? '0 :
                 (in_op == OP_INS_BACK)  ? count_w : pos_w;
    case (in_op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        // index check comes before the full check
        if (ins_pos > count_w) begin
          res_status = ST_BAD_INDEX;
        end else if (count == CAP_CNT) begin
          res_status = ST_FULL;
        end else begin
          ctrl.ins   = accept;
          ctrl.idx   = IDX_W'(ins_pos);
          count_next = count + 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.del   = accept;
          ctrl.idx   = (in_op == OP_REM_FRONT) ? '0 : IDX_W'(count - 1'b1);
          count_next = count - 1'b1;
        end
      end
      OP_REM_AT: begin
        if (pos_w >= count_w) begin
          res_status = ST_BAD_INDEX;
        end else begin
          ctrl.del   = accept;
          ctrl.idx   = IDX_W'(pos_w);
          count_next = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        ctrl.srch = accept;
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t prev_d;
    entry_t next_d;
    if (g == 0) begin : g_first
      assign prev_d = ctrl.val;
    end else begin : g_mid
      assign prev_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_d = cell_data[g];
    end else begin : g_inner
      assign next_d = cell_data[g+1];
    end
    oaids_cell u_cell (
      .clk        (clk),
      .cell_index (IDX_W'(g)),
      .ctrl       (ctrl),
      .prev_data  (prev_d),
      .next_data  (next_d),
      .data       (cell_data[g]),
      .match      (hits[g])
    );
  end

  oaids_prio u_prio (
    .hits    (hits),
    .hit_any (hit_any),
    .hit_idx (hit_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        count <= count_next;
        if (in_op == OP_SEARCH) begin
          state <= ST_SRCH;
        end else begin
          m_tvalid <= 1'b1;
        end
      end
      if (state == ST_SRCH) begin
        state    <= ST_IDLE;
        m_tvalid <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && (in_op != OP_SEARCH)) begin
      status      <= res_status;
      found_index <= '0;
      entry_count <= 7'(count_next);
    end else if (state == ST_SRCH) begin
      status      <= hit_any ? ST_DONE : ST_NOT_FOUND;
      found_index <= hit_any ? 6'(hit_idx) : '0;
      entry_count <= 7'(count);
    end
  end

endmodule

`default_nettype wire

FILE: design/oaids_cell.sv
// One slot of the ordered list: holds an entry, shifts with its neighbors
// on insert and remove, and registers its own search match.
// Depends on oaids_pkg.
`default_nettype none

module oaids_cell
  import oaids_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] cell_index,
  input  wire cell_ctrl_t       ctrl,
  input  wire entry_t           prev_data,
  input  wire entry_t           next_data,
  output entry_t                data,
  output logic                  match
);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      // open the gap: slots above the target take their lower neighbor
      if (cell_index > ctrl.idx) begin
        data <= prev_data;
      end else if (cell_index == ctrl.idx) begin
        data <= ctrl.val;
      end
    end else if (ctrl.del) begin
      if (cell_index >= ctrl.idx) begin
        data <= next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.srch) begin
      match <= (CNT_W'(cell_index) < ctrl.cnt) && (data == ctrl.val);
    end
  end

endmodule

`default_nettype wire

FILE: design/oaids_prio.sv
// Lowest-index priority encoder over the registered match bits of the cells.
// Depends on oaids_pkg.
`default_nettype none

module oaids_prio
  import oaids_pkg::*;
(
  input  wire logic [CAPACITY-1:0] hits,
  output logic                     hit_any,
  output logic [IDX_W-1:0]         hit_idx
);

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire
